### rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Clocked on clock, disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock edge
`define ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/socks5_pkg.sv
// Package for the SOCKS5 request parser: phase enum, word structs and codes.
// No dependencies.
`default_nettype none

package socks5_pkg;

   typedef enum logic [3:0] {
      PH_NMETH    = 4'd0,
      PH_METHODS  = 4'd1,
      PH_VER      = 4'd2,
      PH_CMD      = 4'd3,
      PH_RSV      = 4'd4,
      PH_ATYP     = 4'd5,
      PH_CMD_BAD  = 4'd6,
      PH_RSV_BAD  = 4'd7,
      PH_ATYP_BAD = 4'd8,
      PH_IPV4     = 4'd9,
      PH_NAMELEN  = 4'd10,
      PH_NAME     = 4'd11,
      PH_PORT_HI  = 4'd12,
      PH_PORT_LO  = 4'd13,
      PH_DONE     = 4'd14
   } phase_type;

   localparam logic       REQ_BYTE    = 1'b0;
   localparam logic       REQ_RESTART = 1'b1;

   localparam logic [2:0] KIND_METHOD = 3'd0;
   localparam logic [2:0] KIND_NAME   = 3'd1;
   localparam logic [2:0] KIND_READY  = 3'd2;
   localparam logic [2:0] KIND_REFUSE = 3'd3;
   localparam logic [2:0] KIND_DROP   = 3'd4;

   localparam logic [3:0] CODE_NONE        = 4'd0;
   localparam logic [3:0] CODE_CMD_UNSUP   = 4'd7;
   localparam logic [3:0] CODE_ATYP_UNSUP  = 4'd8;

   localparam logic [7:0] SOCKS_VERSION = 8'h05;
   localparam logic [7:0] CMD_CONNECT   = 8'h01;
   localparam logic [7:0] CMD_BIND      = 8'h02;
   localparam logic [7:0] ATYP_IPV4     = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
   localparam logic [7:0] IPV4_BYTES    = 8'd4;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [3:0]  reply_code;
      logic [7:0]  command;
      logic [7:0]  address_type;
      logic [31:0] ipv4_address;
      logic [15:0] dest_port;
      logic [7:0]  name_byte;
      logic        last_name_byte;
   } rsp_word_type;

endpackage

`default_nettype wire

### rtl/socks5_in_reg.sv
// Input register stage: holds one request word until the parser takes it.
// Depends on socks5_pkg.
`default_nettype none

module socks5_in_reg
   import socks5_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   input  wire logic         advance,
   output logic              word_valid,
   output req_word_type      word
);

   logic         valid_ff, valid_in;
   req_word_type word_ff;
   logic         accept;

   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign valid_in  = accept | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

`default_nettype wire

### rtl/socks5_parse.sv
// Parser state machine: phase and gathered fields, plus the result word
// produced by the current byte. Depends on socks5_pkg.
`default_nettype none

module socks5_parse
   import socks5_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_word_type word,
   output logic              res_valid,
   output rsp_word_type      res
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  saved_command_ff, saved_command_in;
   logic [7:0]  saved_atyp_ff, saved_atyp_in;
   logic [31:0] address_shift_ff, address_shift_in;
   logic [7:0]  port_high_ff, port_high_in;

   logic [7:0]  b;
   logic [7:0]  dec;
   logic        restart;
   logic        emit;

   assign b       = word.data_byte;
   assign dec     = bytes_left_ff - 8'd1;
   assign restart = (word.req_type == REQ_RESTART);

   // next state
   always_comb begin
      phase_in         = phase_ff;
      bytes_left_in    = bytes_left_ff;
      saved_command_in = saved_command_ff;
      saved_atyp_in    = saved_atyp_ff;
      address_shift_in = address_shift_ff;
      port_high_in     = port_high_ff;
      if (restart) begin
         phase_in         = PH_NMETH;
         bytes_left_in    = 8'd0;
         saved_command_in = 8'd0;
         saved_atyp_in    = 8'd0;
         address_shift_in = 32'd0;
         port_high_in     = 8'd0;
      end else begin
         case (phase_ff)
            PH_NMETH: begin
               bytes_left_in = b;
               phase_in      = (b == 8'd0) ? PH_VER : PH_METHODS;
            end
            PH_METHODS: begin
               bytes_left_in = dec;
               if (dec == 8'd0) begin
                  phase_in = PH_VER;
               end
            end
            PH_VER:      phase_in = (b == SOCKS_VERSION) ? PH_CMD : PH_CMD_BAD;
            PH_CMD: begin
               saved_command_in = b;
               phase_in         = PH_RSV;
            end
            PH_RSV:      phase_in = PH_ATYP;
            PH_CMD_BAD:  phase_in = PH_RSV_BAD;
            PH_RSV_BAD:  phase_in = PH_ATYP_BAD;
            PH_ATYP_BAD: phase_in = PH_DONE;
            PH_ATYP: begin
               saved_atyp_in = b;
               if (b == ATYP_IPV4) begin
                  address_shift_in = 32'd0;
                  bytes_left_in    = IPV4_BYTES;
                  phase_in         = PH_IPV4;
               end else if (b == ATYP_DOMAIN) begin
                  phase_in = PH_NAMELEN;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_IPV4: begin
               address_shift_in = {address_shift_ff[23:0], b};
               bytes_left_in    = dec;
               if (dec == 8'd0) begin
                  phase_in = PH_PORT_HI;
               end
            end
            PH_NAMELEN: begin
               if (b == 8'd0) begin
                  phase_in = PH_DONE;
               end else begin
                  bytes_left_in = b;
                  phase_in      = PH_NAME;
               end
            end
            PH_NAME: begin
               bytes_left_in = dec;
               if (dec == 8'd0) begin
                  phase_in = PH_PORT_HI;
               end
            end
            PH_PORT_HI: begin
               port_high_in = b;
               phase_in     = PH_PORT_LO;
            end
            PH_PORT_LO:  phase_in = PH_DONE;
            default:     phase_in = PH_DONE;
         endcase
      end
   end

   // result word
   always_comb begin
      emit               = 1'b0;
      res                = '0;
      res.result_kind    = KIND_METHOD;
      res.reply_code     = CODE_NONE;
      res.command        = saved_command_ff;
      res.address_type   = saved_atyp_ff;
      res.ipv4_address   = (saved_atyp_ff == ATYP_IPV4) ? address_shift_ff : 32'd0;
      case (phase_ff)
         PH_NMETH: begin
            emit = (b == 8'd0);
         end
         PH_METHODS: begin
            emit = (dec == 8'd0);
         end
         PH_ATYP_BAD: begin
            emit            = 1'b1;
            res.result_kind = KIND_DROP;
         end
         PH_ATYP: begin
            emit             = (b != ATYP_IPV4) && (b != ATYP_DOMAIN);
            res.result_kind  = KIND_REFUSE;
            res.reply_code   = CODE_ATYP_UNSUP;
            res.address_type = b;
            res.ipv4_address = 32'd0;
         end
         PH_NAMELEN: begin
            emit            = (b == 8'd0);
            res.result_kind = KIND_REFUSE;
            res.reply_code  = CODE_CMD_UNSUP;
         end
         PH_NAME: begin
            emit               = 1'b1;
            res.result_kind    = KIND_NAME;
            res.name_byte      = b;
            res.last_name_byte = (bytes_left_ff == 8'd1);
         end
         PH_PORT_LO: begin
            emit          = 1'b1;
            res.dest_port = {port_high_ff, b};
            if ((saved_command_ff == CMD_CONNECT) || (saved_command_ff == CMD_BIND)) begin
               res.result_kind = KIND_READY;
            end else begin
               res.result_kind = KIND_REFUSE;
               res.reply_code  = CODE_CMD_UNSUP;
            end
         end
         default: emit = 1'b0;
      endcase
      // method reply and drop carry no context
      if ((res.result_kind == KIND_METHOD) || (res.result_kind == KIND_DROP)) begin
         res.command      = 8'd0;
         res.address_type = 8'd0;
         res.ipv4_address = 32'd0;
      end
      res_valid = step & ~restart & emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_NMETH;
         bytes_left_ff    <= 8'd0;
         saved_command_ff <= 8'd0;
         saved_atyp_ff    <= 8'd0;
         address_shift_ff <= 32'd0;
         port_high_ff     <= 8'd0;
      end else if (step) begin
         phase_ff         <= phase_in;
         bytes_left_ff    <= bytes_left_in;
         saved_command_ff <= saved_command_in;
         saved_atyp_ff    <= saved_atyp_in;
         address_shift_ff <= address_shift_in;
         port_high_ff     <= port_high_in;
      end
   end

endmodule

`default_nettype wire

### rtl/socks5_out_reg.sv
// Result register: holds one response word until the sink takes it.
// Depends on socks5_pkg.
`default_nettype none

module socks5_out_reg
   import socks5_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire rsp_word_type res,
   output logic              free,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   assign free     = ~valid_ff | ~rsp_stall;
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

`default_nettype wire

### rtl/socks5_request_parser.sv
// Top level of the SOCKS5 request parser: input register, parser, result register.
// Depends on socks5_pkg, socks5_in_reg, socks5_parse, socks5_out_reg, assert_macros.svh.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   req     | req_valid/req_stall  | req_type, req_data_byte
//   rsp     | rsp_valid/rsp_stall  | kind, code, command, address type, ipv4, port,
//           |                      | name byte, last flag
//
// One word per cycle sustained while rsp is not stalled. A word waits in the input register
// until it is parsed there; its result (if any) shows on rsp in the cycle after.
// Synchronous reset clears both valid flags and the parser phase.
// The parser steps only when the result register is empty or draining, so a
// stall on rsp reaches req_stall in the same cycle once the input register is full.
`default_nettype none
`include "assert_macros.svh"

module socks5_request_parser
   import socks5_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_result_kind,
   output logic [3:0]       rsp_reply_code,
   output logic [7:0]       rsp_command,
   output logic [7:0]       rsp_address_type,
   output logic [31:0]      rsp_ipv4_address,
   output logic [15:0]      rsp_dest_port,
   output logic [7:0]       rsp_name_byte,
   output logic             rsp_last_name_byte
);

   req_word_type req_word;
   req_word_type word;
   logic         word_valid;
   logic         out_free;
   logic         advance;
   logic         res_valid;
   rsp_word_type res;
   rsp_word_type rsp_word;

   assign req_word.req_type  = req_type;
   assign req_word.data_byte = req_data_byte;
   assign advance            = word_valid & out_free;

   socks5_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .advance    (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   socks5_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .word      (word),
      .res_valid (res_valid),
      .res       (res)
   );

   socks5_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .res       (res),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_result_kind    = rsp_word.result_kind;
   assign rsp_reply_code     = rsp_word.reply_code;
   assign rsp_command        = rsp_word.command;
   assign rsp_address_type   = rsp_word.address_type;
   assign rsp_ipv4_address   = rsp_word.ipv4_address;
   assign rsp_dest_port      = rsp_word.dest_port;
   assign rsp_name_byte      = rsp_word.name_byte;
   assign rsp_last_name_byte = rsp_word.last_name_byte;

   `ASSERT_NEXT(a_held_word_kept, word_valid && !advance, word_valid)
   `ASSERT_IMPLIES(a_name_is_domain, rsp_valid && (rsp_result_kind == KIND_NAME), rsp_address_type == ATYP_DOMAIN)
   `ASSERT_IMPLIES(a_code_only_refuse, rsp_valid, (rsp_result_kind == KIND_REFUSE) == (rsp_reply_code != CODE_NONE))
   `ASSERT_IMPLIES(a_ipv4_only_type1, rsp_valid && (rsp_ipv4_address != 32'd0), rsp_address_type == ATYP_IPV4)

endmodule

`default_nettype wire
